// ===== hw/rtl/ctc_pkg.sv =====
// ----------------------------------------------------------------------------
// ctc_pkg
// Types, constants and calendar helpers shared by the calendar clock core.
// ----------------------------------------------------------------------------
`default_nettype none

package ctc_pkg;

	localparam int YEAR_BITS = 16;

	typedef logic [YEAR_BITS-1:0] year_t;
	typedef logic [3:0]           month_t;
	typedef logic [4:0]           day_t;
	typedef logic [4:0]           hour_t;
	typedef logic [5:0]           minute_t;
	typedef logic [5:0]           second_t;

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_LOAD = 1'b1
	} cmd_t;

	typedef struct packed {
		year_t   year;
		month_t  month;
		day_t    day;
		hour_t   hour;
		minute_t minute;
		second_t second;
	} date_t;

	typedef struct packed {
		cmd_t    cmd;
		year_t   year;
		month_t  month;
		day_t    day;
		hour_t   hour;
		minute_t minute;
		second_t second;
	} req_t;

	localparam month_t  MONTH_JAN   = 4'd1;
	localparam month_t  MONTH_FEB   = 4'd2;
	localparam month_t  MONTH_DEC   = 4'd12;
	localparam day_t    DAY_FIRST   = 5'd1;
	localparam day_t    DAY_LEAP    = 5'd29;
	localparam hour_t   HOUR_LAST   = 5'd23;
	localparam minute_t MINUTE_LAST = 6'd59;
	localparam second_t SECOND_LAST = 6'd59;
	localparam hour_t   HOURS       = 5'd24;
	localparam minute_t MINUTES     = 6'd60;
	localparam second_t SECONDS     = 6'd60;

	localparam logic [63:0] YEAR_SPAN  = (64'd1 << YEAR_BITS) - 64'd1;
	localparam year_t       YEAR_MAX   = YEAR_SPAN[YEAR_BITS-1:0];
	localparam logic [63:0] YEAR_DFLT_W = 64'd2000;
	localparam year_t       YEAR_DFLT  = YEAR_DFLT_W[YEAR_BITS-1:0];

	localparam date_t RESET_DATE = '{
		year:   YEAR_DFLT,
		month:  MONTH_JAN,
		day:    DAY_FIRST,
		hour:   '0,
		minute: '0,
		second: '0
	};

	// inverse of 25 modulo 2^64 by Newton steps; used for an exact divisibility test
	function automatic logic [63:0] calc_inv25();
		logic [63:0] x;
		x = 64'd25;
		for (int i = 0; i < 6; i++) begin
			x = x * (64'd2 - 64'd25 * x);
		end
		return x;
	endfunction

	localparam logic [63:0] INV25_W   = calc_inv25();
	localparam year_t       INV25     = INV25_W[YEAR_BITS-1:0];
	localparam logic [63:0] DIV25_W   = YEAR_SPAN / 25;
	localparam year_t       DIV25_LIM = DIV25_W[YEAR_BITS-1:0];

	localparam day_t MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	function automatic logic is_leap(input year_t y);
		year_t prod;
		logic  div25;
		prod  = y * INV25;
		div25 = (prod <= DIV25_LIM);
		return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
	endfunction

	function automatic day_t days_in(input month_t m, input year_t y);
		day_t len;
		if ((m < MONTH_JAN) || (m > MONTH_DEC)) begin
			len = 5'd31;
		end else if ((m == MONTH_FEB) && is_leap(y)) begin
			len = DAY_LEAP;
		end else begin
			len = MONTH_LEN[m - MONTH_JAN];
		end
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ctc_step.sv =====
// ----------------------------------------------------------------------------
// ctc_step
// Next date and time for one request: either a one-second tick cascade or a
// validated load of a new date and time.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_step (
	input  wire ctc_pkg::req_t  req,
	input  wire ctc_pkg::date_t cur,
	output ctc_pkg::date_t      nxt
);

	ctc_pkg::date_t  load_d;
	ctc_pkg::date_t  tick_d;
	ctc_pkg::day_t   load_len;
	ctc_pkg::day_t   cur_len;
	logic            sec_wrap;
	logic            min_wrap;
	logic            hour_wrap;
	logic            day_wrap;
	logic            mon_wrap;

	always_comb begin
		load_d.year   = (req.year != '0) ? req.year : ctc_pkg::YEAR_DFLT;
		load_d.month  = (req.month inside {[ctc_pkg::MONTH_JAN:ctc_pkg::MONTH_DEC]}) ?
			req.month : ctc_pkg::MONTH_JAN;
		load_len      = ctc_pkg::days_in(load_d.month, load_d.year);
		load_d.day    = ((req.day >= ctc_pkg::DAY_FIRST) && (req.day <= load_len)) ?
			req.day : ctc_pkg::DAY_FIRST;
		load_d.hour   = (req.hour < ctc_pkg::HOURS) ? req.hour : '0;
		load_d.minute = (req.minute < ctc_pkg::MINUTES) ? req.minute : '0;
		load_d.second = (req.second < ctc_pkg::SECONDS) ? req.second : '0;
	end

	always_comb begin
		cur_len   = ctc_pkg::days_in(cur.month, cur.year);
		sec_wrap  = (cur.second == ctc_pkg::SECOND_LAST);
		min_wrap  = sec_wrap && (cur.minute == ctc_pkg::MINUTE_LAST);
		hour_wrap = min_wrap && (cur.hour == ctc_pkg::HOUR_LAST);
		day_wrap  = hour_wrap && (cur.day >= cur_len);
		mon_wrap  = day_wrap && (cur.month >= ctc_pkg::MONTH_DEC);

		tick_d = cur;
		tick_d.second = sec_wrap ? '0 : cur.second + 6'd1;
		if (sec_wrap) begin
			tick_d.minute = min_wrap ? '0 : cur.minute + 6'd1;
		end
		if (min_wrap) begin
			tick_d.hour = hour_wrap ? '0 : cur.hour + 5'd1;
		end
		if (hour_wrap) begin
			tick_d.day = day_wrap ? ctc_pkg::DAY_FIRST : cur.day + 5'd1;
		end
		if (day_wrap) begin
			tick_d.month = mon_wrap ? ctc_pkg::MONTH_JAN : cur.month + 4'd1;
		end
		if (mon_wrap && (cur.year != ctc_pkg::YEAR_MAX)) begin
			tick_d.year = cur.year + ctc_pkg::year_t'(1);
		end
	end

	assign nxt = (req.cmd == ctc_pkg::CMD_LOAD) ? load_d : tick_d;

endmodule

`default_nettype wire

// ===== hw/rtl/calendar_clock_tick_core.sv =====
// ----------------------------------------------------------------------------
// calendar_clock_tick_core
// Gregorian calendar clock: one-second ticks and date/time load requests.
// ----------------------------------------------------------------------------
// Each request is a one-second tick or a load of a new date and time, and each
// gives exactly one result: the date and time after it. One request is taken
// every cycle unless the result side stalls; a request passes through the input
// register, then the calendar registers, which also serve as the result register.
// The rate is set by the update of the calendar registers. A stall on
// the result side holds the result and the calendar state.
`default_nettype none

module calendar_clock_tick_core (
	input  wire         clk,
	input  wire         arst_n,

	input  wire         req_valid,
	output logic        req_stall,
	input  wire         cmd,
	input  wire  [15:0] new_year,
	input  wire  [3:0]  new_month,
	input  wire  [4:0]  new_day,
	input  wire  [4:0]  new_hour,
	input  wire  [5:0]  new_minute,
	input  wire  [5:0]  new_second,

	output logic        res_valid,
	input  wire         res_stall,
	output logic [15:0] cur_year,
	output logic [3:0]  cur_month,
	output logic [4:0]  cur_day,
	output logic [4:0]  cur_hour,
	output logic [5:0]  cur_minute,
	output logic [5:0]  cur_second
);

	ctc_pkg::req_t  req_s1;
	logic           valid_s1;
	logic           res_valid_q;
	ctc_pkg::date_t date_q;
	ctc_pkg::date_t date_nxt;
	logic           adv;
	logic [31:0]    year_in_w;
	logic [31:0]    year_out_w;

	assign adv       = ~res_valid_q | ~res_stall;
	assign req_stall = valid_s1 & ~adv;
	assign year_in_w = 32'(new_year);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			date_q      <= ctc_pkg::RESET_DATE;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (adv) begin
				res_valid_q <= valid_s1;
			end
			if (adv && valid_s1) begin
				date_q <= date_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1.cmd    <= ctc_pkg::cmd_t'(cmd);
			req_s1.year   <= year_in_w[ctc_pkg::YEAR_BITS-1:0];
			req_s1.month  <= new_month;
			req_s1.day    <= new_day;
			req_s1.hour   <= new_hour;
			req_s1.minute <= new_minute;
			req_s1.second <= new_second;
		end
	end

	ctc_step u_step (
		.req (req_s1),
		.cur (date_q),
		.nxt (date_nxt)
	);

	assign year_out_w = 32'(date_q.year);
	assign res_valid  = res_valid_q;
	assign cur_year   = year_out_w[15:0];
	assign cur_month  = date_q.month;
	assign cur_day    = date_q.day;
	assign cur_hour   = date_q.hour;
	assign cur_minute = date_q.minute;
	assign cur_second = date_q.second;

endmodule

`default_nettype wire

// ===== tb/tb_calendar_clock_tick_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_clock_tick_core
// Self-checking bench for the Gregorian calendar clock core.
// ----------------------------------------------------------------------------
// A short table of directed requests covers the field extremes, load
// clamping, leap-year rules, rollover and year saturation. Random requests
// follow: mostly single ticks, plus loads parked just before a rollover with
// bursts of ticks, long tick runs and fully random loads. Each result is checked
// in order against a table row or the calendar model, in four idle/stall phases.

module tb_calendar_clock_tick_core;

	import ctc_pkg::*;

	localparam int RANDOM_REQS = 1350;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic  chk;
		req_t  req;
		date_t exp;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic        cmd = 1'b0;
	logic [15:0] new_year = '0;
	logic [3:0]  new_month = '0;
	logic [4:0]  new_day = '0;
	logic [4:0]  new_hour = '0;
	logic [5:0]  new_minute = '0;
	logic [5:0]  new_second = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [15:0] cur_year;
	logic [3:0]  cur_month;
	logic [4:0]  cur_day;
	logic [4:0]  cur_hour;
	logic [5:0]  cur_minute;
	logic [5:0]  cur_second;

	date_t    calendar;
	date_t    expected_dates[$];
	dir_row_t dir_rows[$];
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       mismatches = 0;
	int       results_seen = 0;
	int       loads_sent = 0;
	int       ticks_sent = 0;
	int       tick_burst = 0;
	int       cycles = 0;

	calendar_clock_tick_core uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .cmd(cmd),
		.new_year(new_year), .new_month(new_month), .new_day(new_day),
		.new_hour(new_hour), .new_minute(new_minute), .new_second(new_second),
		.res_valid(res_valid), .res_stall(res_stall),
		.cur_year(cur_year), .cur_month(cur_month), .cur_day(cur_day),
		.cur_hour(cur_hour), .cur_minute(cur_minute), .cur_second(cur_second)
	);

	always #4 clk = ~clk;

	function automatic bit leap_year(int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_days(int unsigned m, int unsigned y);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap_year(y) ? 29 : 28;
			default:               return 31;
		endcase
	endfunction

	function automatic date_t advance_calendar(date_t c, req_t r);
		date_t n;
		n = c;
		if (r.cmd == CMD_LOAD) begin
			n.year   = (r.year != '0) ? r.year : YEAR_DFLT;
			n.month  = (r.month >= 1 && r.month <= 12) ? r.month : month_t'(1);
			n.day    = (r.day >= 1 && r.day <= month_days(n.month, n.year)) ? r.day : day_t'(1);
			n.hour   = (r.hour < 24) ? r.hour : '0;
			n.minute = (r.minute < 60) ? r.minute : '0;
			n.second = (r.second < 60) ? r.second : '0;
		end else if (c.second != 59) begin
			n.second = c.second + 1'b1;
		end else begin
			n.second = '0;
			if (c.minute != 59) begin
				n.minute = c.minute + 1'b1;
			end else begin
				n.minute = '0;
				if (c.hour != 23) begin
					n.hour = c.hour + 1'b1;
				end else begin
					n.hour = '0;
					if (c.day < month_days(c.month, c.year)) begin
						n.day = c.day + 1'b1;
					end else begin
						n.day = day_t'(1);
						if (c.month < 12) begin
							n.month = c.month + 1'b1;
						end else begin
							n.month = month_t'(1);
							if (c.year != YEAR_MAX)
								n.year = c.year + 1'b1;
						end
					end
				end
			end
		end
		return n;
	endfunction

	function automatic dir_row_t mk(cmd_t c, int y, int mo, int d, int h, int mi, int s,
			bit chk, int ey = 0, int emo = 0, int ed = 0, int eh = 0, int emi = 0,
			int es = 0);
		dir_row_t row;
		row.chk        = chk;
		row.req.cmd    = c;
		row.req.year   = year_t'(y);
		row.req.month  = month_t'(mo);
		row.req.day    = day_t'(d);
		row.req.hour   = hour_t'(h);
		row.req.minute = minute_t'(mi);
		row.req.second = second_t'(s);
		row.exp.year   = year_t'(ey);
		row.exp.month  = month_t'(emo);
		row.exp.day    = day_t'(ed);
		row.exp.hour   = hour_t'(eh);
		row.exp.minute = minute_t'(emi);
		row.exp.second = second_t'(es);
		return row;
	endfunction

	task automatic note_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	function automatic string fmt_date(date_t d);
		return $sformatf("%0d-%0d-%0d %0d:%0d:%0d",
			d.year, d.month, d.day, d.hour, d.minute, d.second);
	endfunction

	task automatic send_req(req_t r, bit chk, date_t exp);
		while ((send_idle_pct != 0) && ($urandom_range(99) < send_idle_pct)) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		cmd        <= r.cmd;
		new_year   <= r.year;
		new_month  <= r.month;
		new_day    <= r.day;
		new_hour   <= r.hour;
		new_minute <= r.minute;
		new_second <= r.second;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		calendar = advance_calendar(calendar, r);
		expected_dates.push_back(chk ? exp : calendar);
		if (r.cmd == CMD_LOAD)
			loads_sent++;
		else
			ticks_sent++;
	endtask

	task automatic gen_random_req(output req_t r);
		int unsigned pick;
		int unsigned y;
		r.cmd    = CMD_TICK;
		r.year   = year_t'($urandom_range(16'hFFFF, 0));
		r.month  = month_t'($urandom_range(15, 0));
		r.day    = day_t'($urandom_range(31, 0));
		r.hour   = hour_t'($urandom_range(31, 0));
		r.minute = minute_t'($urandom_range(63, 0));
		r.second = second_t'($urandom_range(63, 0));
		if (tick_burst > 0) begin
			tick_burst--;
			return;
		end
		pick = $urandom_range(99);
		if (pick < 52) begin
			return;
		end else if (pick < 57) begin
			tick_burst = $urandom_range(80, 20);
		end else if (pick < 88) begin
			case ($urandom_range(7))
				0:       y = 1900;
				1:       y = 2000;
				2:       y = 2100;
				3:       y = 2400;
				4:       y = YEAR_MAX;
				5:       y = $urandom_range(2104, 1970) & ~32'd3;
				default: y = $urandom_range(16'hFFFF, 1);
			endcase
			r.cmd    = CMD_LOAD;
			r.year   = year_t'(y);
			r.month  = month_t'($urandom_range(12, 1));
			r.day    = day_t'(month_days(r.month, y) - $urandom_range(1, 0));
			r.hour   = ($urandom_range(3) != 0) ? HOUR_LAST : hour_t'($urandom_range(23, 0));
			r.minute = ($urandom_range(3) != 0) ? MINUTE_LAST : minute_t'($urandom_range(59, 0));
			r.second = second_t'($urandom_range(59, 56));
			tick_burst = $urandom_range(6, 1);
		end else begin
			r.cmd = CMD_LOAD;
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		date_t got;
		date_t want;
		if (arst_n && res_valid && !res_stall) begin
			got = '{cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second};
			results_seen++;
			if (expected_dates.size() == 0) begin
				note_mismatch($sformatf("unexpected result %s", fmt_date(got)));
			end else begin
				want = expected_dates.pop_front();
				if (got.year !== want.year || got.month !== want.month ||
						got.day !== want.day || got.hour !== want.hour ||
						got.minute !== want.minute || got.second !== want.second)
					note_mismatch($sformatf("expected %s, got %s",
						fmt_date(want), fmt_date(got)));
			end
		end
		res_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
	end

	initial begin
		req_t r;
		int   ph;
		calendar = RESET_DATE;

		// tick from reset, clamping, extremes, leap rules, rollovers
		dir_rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 1, 2000, 1, 1, 0, 0, 1));
		dir_rows.push_back(mk(CMD_LOAD, 0, 0, 0, 31, 63, 63, 1, 2000, 1, 1, 0, 0, 0));
		dir_rows.push_back(mk(CMD_LOAD, 65535, 15, 31, 24, 60, 60, 1,
			65535, 1, 31, 0, 0, 0));
		dir_rows.push_back(mk(CMD_LOAD, 65535, 12, 31, 23, 59, 59, 1,
			65535, 12, 31, 23, 59, 59));
		dir_rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 1, 65535, 1, 1, 0, 0, 0));
		dir_rows.push_back(mk(CMD_LOAD, 2023, 2, 29, 12, 30, 30, 1,
			2023, 2, 1, 12, 30, 30));
		dir_rows.push_back(mk(CMD_LOAD, 2024, 2, 29, 0, 0, 0, 1, 2024, 2, 29, 0, 0, 0));
		dir_rows.push_back(mk(CMD_LOAD, 1900, 2, 29, 1, 2, 3, 1, 1900, 2, 1, 1, 2, 3));
		dir_rows.push_back(mk(CMD_LOAD, 2000, 2, 29, 4, 5, 6, 1, 2000, 2, 29, 4, 5, 6));
		dir_rows.push_back(mk(CMD_LOAD, 2021, 4, 31, 7, 8, 9, 1, 2021, 4, 1, 7, 8, 9));
		dir_rows.push_back(mk(CMD_LOAD, 2021, 6, 0, 23, 59, 59, 1,
			2021, 6, 1, 23, 59, 59));
		dir_rows.push_back(mk(CMD_LOAD, 1, 1, 1, 0, 0, 0, 1, 1, 1, 1, 0, 0, 0));
		dir_rows.push_back(mk(CMD_LOAD, 2024, 2, 28, 23, 59, 59, 0));
		dir_rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk(CMD_LOAD, 2024, 2, 29, 23, 59, 59, 0));
		dir_rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk(CMD_LOAD, 2100, 2, 28, 23, 59, 59, 0));
		dir_rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk(CMD_LOAD, 2400, 2, 28, 23, 59, 59, 0));
		dir_rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk(CMD_LOAD, 1999, 12, 31, 23, 59, 59, 0));
		dir_rows.push_back(mk(CMD_TICK, 65535, 15, 31, 31, 63, 63, 0));
		dir_rows.push_back(mk(CMD_LOAD, 2022, 7, 15, 10, 59, 59, 0));
		dir_rows.push_back(mk(CMD_TICK, 65535, 15, 31, 31, 63, 63, 0));
		dir_rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_req(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].exp);

		for (int i = 0; i < RANDOM_REQS; i++) begin
			ph = (i * 4) / RANDOM_REQS;
			case (ph)
				0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			gen_random_req(r);
			send_req(r, 1'b0, RESET_DATE);
		end
		req_valid <= 1'b0;

		while (expected_dates.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (expected_dates.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", expected_dates.size()));

		$display("Sent %0d loads and %0d ticks; checked %0d results over four idle/stall phases.",
			loads_sent, ticks_sent, results_seen);
		$display("Mismatch count: %0d", mismatches);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== calendar_clock_tick_core.f =====
hw/rtl/ctc_pkg.sv
hw/rtl/ctc_step.sv
hw/rtl/calendar_clock_tick_core.sv
tb/tb_calendar_clock_tick_core.sv
